/* sv/bra_pkg.sv */
`default_nettype none
package bra_pkg;

    localparam int unsigned IR_W     = 18;
    localparam int unsigned FLOOR_W  = 8;
    localparam int unsigned CEIL_W   = 10;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned AVG_W    = 10;
    localparam int unsigned RATE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 18;
    localparam int unsigned DIV_W    = 16;
    localparam int unsigned DCNT_W   = 4;

    localparam logic [DIV_W-1:0]     MS_PER_MINUTE = 16'd60000;
    localparam logic [RATE_W-1:0]    RATE_MAX      = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING  = 2'd2;

    localparam logic [IR_W-1:0]      PRESENCE_RST = 18'd5000;
    localparam logic [FLOOR_W-1:0]   FLOOR_RST    = 8'd20;
    localparam logic [CEIL_W-1:0]    CEILING_RST  = 10'd255;

    typedef struct packed {
        logic capture;
        logic period;
        logic mult;
        logic div_init;
        logic set_acc;
        logic div_step;
        logic store;
        logic sum_step;
        logic finish;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic beat;
        logic in_range;
        logic div_last;
        logic sum_last;
    } t_ctrl_sts;

endpackage
`default_nettype wire

/* sv/beat_rate_averager.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
// in       | i_in_valid / o_in_ready    | i_ir_sample, i_beat_seen, i_now_ms
// out      | o_out_valid / i_out_ready  | o_average_q2, o_finger_present, o_beat_accepted
//
// one sample at a time: the input is ready again only after the last result is loaded
// an accepted beat runs a 16-step restoring divide and a ring sum of one entry per cycle
// the result sits in an output register; a stalled output holds the block in its last step
// reset is synchronous: ring, index, last beat time and held mean clear to zero
// configuration is taken every cycle, an index beyond the register list is ignored
`default_nettype none
module beat_rate_averager #(
    parameter int unsigned RING_DEPTH = 4
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [bra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [bra_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [bra_pkg::IR_W-1:0]       i_ir_sample,
    input  wire                            i_beat_seen,
    input  wire  [bra_pkg::TIME_W-1:0]     i_now_ms,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [bra_pkg::AVG_W-1:0]      o_average_q2,
    output logic                           o_finger_present,
    output logic                           o_beat_accepted
);

    bra_pkg::t_ctrl_cmd cmd;
    bra_pkg::t_ctrl_sts sts;

    assign o_cfg_ready = 1'b1;

    bra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bra_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_ir_sample      (i_ir_sample),
        .i_beat_seen      (i_beat_seen),
        .i_now_ms         (i_now_ms),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_average_q2     (o_average_q2),
        .o_finger_present (o_finger_present),
        .o_beat_accepted  (o_beat_accepted)
    );

endmodule
`default_nettype wire

/* sv/bra_ctrl.sv */
`default_nettype none
module bra_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire bra_pkg::t_ctrl_sts i_sts,
    output bra_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PERIOD,
        S_MULT,
        S_CHECK,
        S_DIV,
        S_STORE,
        S_SUM,
        S_FINISH,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PERIOD;
                end
            end
            S_PERIOD: begin
                if (i_sts.beat) begin
                    o_cmd.period = 1'b1;
                    n_state      = S_MULT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.div_init = 1'b1;
                if (i_sts.in_range) begin
                    o_cmd.set_acc = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a sample is in progress");

    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");

    a_sum_after_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store |=> (r_state == S_SUM))
        else $error("ring sum not started after store");

endmodule
`default_nettype wire

/* sv/bra_datapath.sv */
`default_nettype none
module bra_datapath #(
    parameter int unsigned RING_DEPTH = 4
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    input  wire  [bra_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [bra_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  wire  [bra_pkg::IR_W-1:0]            i_ir_sample,
    input  wire                                 i_beat_seen,
    input  wire  [bra_pkg::TIME_W-1:0]          i_now_ms,
    input  wire bra_pkg::t_ctrl_cmd             i_cmd,
    output bra_pkg::t_ctrl_sts                  o_sts,
    output logic [bra_pkg::AVG_W-1:0]           o_average_q2,
    output logic                                o_finger_present,
    output logic                                o_beat_accepted
);

    localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
    localparam int unsigned SUM_W  = bra_pkg::RATE_W + $clog2(RING_DEPTH);
    localparam int unsigned PC_W   = bra_pkg::CEIL_W + bra_pkg::TIME_W;
    localparam int unsigned PF_W   = bra_pkg::FLOOR_W + bra_pkg::TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam int unsigned RECIP_SH = 20;
    localparam int unsigned MP_W     = SUM_W + 2 + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP =
        RECIP_SH'((2**RECIP_SH + RING_DEPTH - 1) / RING_DEPTH);

    logic [bra_pkg::IR_W-1:0]    r_presence;
    logic [bra_pkg::FLOOR_W-1:0] r_floor;
    logic [bra_pkg::CEIL_W-1:0]  r_ceiling;

    logic [bra_pkg::IR_W-1:0]    r_ir;
    logic                        r_beat;
    logic [bra_pkg::TIME_W-1:0]  r_now;
    logic [bra_pkg::TIME_W-1:0]  r_last;
    logic [bra_pkg::TIME_W-1:0]  r_period;
    logic [PC_W-1:0]             r_prod_ceil;
    logic [PF_W-1:0]             r_prod_floor;
    logic                        r_accepted;

    logic [bra_pkg::DIV_W:0]     r_rem;
    logic [bra_pkg::DIV_W-1:0]   r_quo;
    logic [bra_pkg::DCNT_W-1:0]  r_dcnt;
    logic                        r_big;

    logic [bra_pkg::RATE_W-1:0]  r_ring [RING_DEPTH];
    logic [IDX_W-1:0]            r_widx;
    logic [IDX_W-1:0]            r_sidx;
    logic [SUM_W-1:0]            r_acc;
    logic [bra_pkg::AVG_W-1:0]   r_held;

    logic [bra_pkg::AVG_W-1:0]   r_avg;
    logic                        r_fp;
    logic                        r_bacc;

    logic [bra_pkg::DIV_W:0]     rem_sh;
    logic                        rem_ge;
    logic [bra_pkg::RATE_W-1:0]  rate;
    logic [MP_W-1:0]             mean_prod;
    logic [SUM_W+1:0]            mean_q2;
    logic                        present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presence <= bra_pkg::PRESENCE_RST;
            r_floor    <= bra_pkg::FLOOR_RST;
            r_ceiling  <= bra_pkg::CEILING_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bra_pkg::CFG_PRESENCE: r_presence <= i_cfg_data;
                bra_pkg::CFG_FLOOR:    r_floor    <= i_cfg_data[bra_pkg::FLOOR_W-1:0];
                bra_pkg::CFG_CEILING:  r_ceiling  <= i_cfg_data[bra_pkg::CEIL_W-1:0];
                default: ;
            endcase
        end
    end

    assign rem_sh = {r_rem[bra_pkg::DIV_W-1:0], r_quo[bra_pkg::DIV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_period[bra_pkg::DIV_W-1:0]});

    always_comb begin
        if (r_big) begin
            rate = '0;
        end else if (r_quo > bra_pkg::DIV_W'(bra_pkg::RATE_MAX)) begin
            rate = bra_pkg::RATE_MAX;
        end else begin
            rate = r_quo[bra_pkg::RATE_W-1:0];
        end
    end

    // ring mean by reciprocal multiply, exact over the sum range
    assign mean_prod = MP_W'({r_acc, 2'b00}) * MP_W'(RECIP);
    assign mean_q2   = mean_prod[RECIP_SH +: SUM_W + 2];
    assign present   = (r_ir >= r_presence);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_widx     <= '0;
            r_held     <= '0;
            r_accepted <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (i_cmd.capture) begin
                r_accepted <= 1'b0;
            end
            if (i_cmd.set_acc) begin
                r_accepted <= 1'b1;
            end
            if (i_cmd.period) begin
                r_last <= r_now;
            end
            if (i_cmd.store) begin
                r_ring[r_widx] <= rate;
                r_widx         <= (r_widx == LAST_IDX) ? '0 : r_widx + 1'b1;
            end
            if (i_cmd.finish) begin
                r_held <= mean_q2[bra_pkg::AVG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ir   <= i_ir_sample;
            r_beat <= i_beat_seen;
            r_now  <= i_now_ms;
        end
        if (i_cmd.period) begin
            r_period <= r_now - r_last;
        end
        if (i_cmd.mult) begin
            r_prod_ceil  <= PC_W'(r_ceiling) * PC_W'(r_period);
            r_prod_floor <= PF_W'(r_floor) * PF_W'(r_period);
        end
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= bra_pkg::MS_PER_MINUTE;
            r_dcnt <= '0;
            r_big  <= (r_period[bra_pkg::TIME_W-1:bra_pkg::DIV_W] != '0);
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? (rem_sh - {1'b0, r_period[bra_pkg::DIV_W-1:0]}) : rem_sh;
            r_quo  <= {r_quo[bra_pkg::DIV_W-2:0], rem_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.store) begin
            r_acc  <= '0;
            r_sidx <= '0;
        end else if (i_cmd.sum_step) begin
            r_acc  <= r_acc + SUM_W'(r_ring[r_sidx]);
            r_sidx <= r_sidx + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_avg  <= present ? r_held : '0;
            r_fp   <= present;
            r_bacc <= r_accepted;
        end
    end

    assign o_sts.beat     = r_beat;
    assign o_sts.in_range = (r_period != '0)
                          && (PC_W'(bra_pkg::MS_PER_MINUTE) < r_prod_ceil)
                          && (PF_W'(bra_pkg::MS_PER_MINUTE) > r_prod_floor);
    assign o_sts.div_last = (r_dcnt == bra_pkg::DCNT_W'(bra_pkg::DIV_W - 1));
    assign o_sts.sum_last = (r_sidx == LAST_IDX);

    assign o_average_q2     = r_avg;
    assign o_finger_present = r_fp;
    assign o_beat_accepted  = r_bacc;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= bra_pkg::AVG_W'(4 * 255))
        else $error("held mean out of range");

    a_index_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |=> (r_widx != $past(r_widx)))
        else $error("ring index did not advance on store");

    a_accept_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_acc |-> (r_beat && r_period != '0))
        else $error("rate accepted without a beat");

endmodule
`default_nettype wire

/* tb/beat_rate_checker.sv */
`timescale 1ns / 100ps
module beat_rate_checker #(
    parameter int unsigned RING_DEPTH = 4
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    input  wire                            i_cfg_ready,
    input  wire  [bra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [bra_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    input  wire                            i_in_ready,
    input  wire  [bra_pkg::IR_W-1:0]       i_ir_sample,
    input  wire                            i_beat_seen,
    input  wire  [bra_pkg::TIME_W-1:0]     i_now_ms,
    input  wire                            i_out_valid,
    input  wire                            i_out_ready,
    input  wire  [bra_pkg::AVG_W-1:0]      i_average_q2,
    input  wire                            i_finger_present,
    input  wire                            i_beat_accepted,
    output int                             o_pending,
    output int                             o_fail_count
);

    typedef struct packed {
        logic [bra_pkg::AVG_W-1:0] average_q2;
        logic                      finger_present;
        logic                      beat_accepted;
    } t_reading;

    logic [bra_pkg::IR_W-1:0]    threshold_q;
    logic [bra_pkg::FLOOR_W-1:0] floor_q;
    logic [bra_pkg::CEIL_W-1:0]  ceiling_q;
    logic [bra_pkg::RATE_W-1:0]  rates_q [RING_DEPTH];
    int unsigned                 slot_q;
    logic [bra_pkg::TIME_W-1:0]  last_beat_q;
    logic [bra_pkg::AVG_W-1:0]   mean_q;
    t_reading                    expected_readings [$];
    int                          fail_count = 0;

    task automatic clear_model();
        threshold_q = bra_pkg::PRESENCE_RST;
        floor_q     = bra_pkg::FLOOR_RST;
        ceiling_q   = bra_pkg::CEILING_RST;
        foreach (rates_q[k]) rates_q[k] = '0;
        slot_q      = 0;
        last_beat_q = '0;
        mean_q      = '0;
    endtask

    task automatic apply_write(input logic [bra_pkg::CFG_IDX_W-1:0] idx,
                               input logic [bra_pkg::CFG_DAT_W-1:0] data);
        case (idx)
            bra_pkg::CFG_PRESENCE: threshold_q = data[bra_pkg::IR_W-1:0];
            bra_pkg::CFG_FLOOR:    floor_q     = data[bra_pkg::FLOOR_W-1:0];
            bra_pkg::CFG_CEILING:  ceiling_q   = data[bra_pkg::CEIL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_reading(input logic [bra_pkg::IR_W-1:0] ir, input logic beat,
                                   input logic [bra_pkg::TIME_W-1:0] now,
                                   output t_reading r);
        logic [bra_pkg::TIME_W-1:0] period;
        logic [63:0]                ceil_span;
        logic [63:0]                floor_span;
        logic [31:0]                rate;
        int unsigned                sum;
        r.beat_accepted = 1'b0;
        if (beat) begin
            period      = now - last_beat_q;
            last_beat_q = now;
            ceil_span   = 64'(ceiling_q) * 64'(period);
            floor_span  = 64'(floor_q) * 64'(period);
            if (period != '0 && ceil_span > 64'(bra_pkg::MS_PER_MINUTE)
                    && floor_span < 64'(bra_pkg::MS_PER_MINUTE)) begin
                rate = 32'(bra_pkg::MS_PER_MINUTE) / period;
                if (rate > 32'(bra_pkg::RATE_MAX)) rate = 32'(bra_pkg::RATE_MAX);
                rates_q[slot_q] = rate[bra_pkg::RATE_W-1:0];
                slot_q = (slot_q + 1) % RING_DEPTH;
                sum = 0;
                foreach (rates_q[k]) sum += rates_q[k];
                mean_q = bra_pkg::AVG_W'((sum * 4) / RING_DEPTH);
                r.beat_accepted = 1'b1;
            end
        end
        r.finger_present = (ir >= threshold_q);
        r.average_q2     = r.finger_present ? mean_q : '0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_reading due;
        t_reading fresh;
        if (!i_rst_n) begin
            clear_model();
            expected_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_write(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result transfer with no sample pending: average_q2 %0d",
                           i_average_q2);
                    fail_count++;
                end else begin
                    due = expected_readings.pop_front();
                    check_field("average_q2", 32'(due.average_q2), 32'(i_average_q2));
                    check_field("finger_present", 32'(due.finger_present),
                                32'(i_finger_present));
                    check_field("beat_accepted", 32'(due.beat_accepted),
                                32'(i_beat_accepted));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_reading(i_ir_sample, i_beat_seen, i_now_ms, fresh);
                expected_readings.push_back(fresh);
            end
        end
        o_pending    <= expected_readings.size();
        o_fail_count <= fail_count;
    end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench;

    localparam int unsigned RING_DEPTH = 4;
    localparam logic [bra_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RANDOM_SAMPLES = 1830;
    localparam int unsigned PHASES = 8;
    localparam int unsigned IR_MAX = 262143;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [bra_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bra_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic [bra_pkg::IR_W-1:0]      i_ir_sample = '0;
    logic                          i_beat_seen = 1'b0;
    logic [bra_pkg::TIME_W-1:0]    i_now_ms = '0;
    logic                          i_out_ready = 1'b0;
    wire                           o_cfg_ready;
    wire                           o_in_ready;
    wire                           o_out_valid;
    wire [bra_pkg::AVG_W-1:0]      o_average_q2;
    wire                           o_finger_present;
    wire                           o_beat_accepted;

    int                            pending;
    int                            mismatches;
    bit                            calm = 1'b0;
    logic [bra_pkg::IR_W-1:0]      cur_threshold = bra_pkg::PRESENCE_RST;
    logic [bra_pkg::TIME_W-1:0]    stamp = '0;

    beat_rate_averager #(.RING_DEPTH(RING_DEPTH)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_ir_sample      (i_ir_sample),
        .i_beat_seen      (i_beat_seen),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_average_q2     (o_average_q2),
        .o_finger_present (o_finger_present),
        .o_beat_accepted  (o_beat_accepted)
    );

    beat_rate_checker #(.RING_DEPTH(RING_DEPTH)) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_ir_sample      (i_ir_sample),
        .i_beat_seen      (i_beat_seen),
        .i_now_ms         (i_now_ms),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_average_q2     (o_average_q2),
        .i_finger_present (o_finger_present),
        .i_beat_accepted  (o_beat_accepted),
        .o_pending        (pending),
        .o_fail_count     (mismatches)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [bra_pkg::IR_W-1:0] pick_ir(input logic [bra_pkg::IR_W-1:0] thr);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return bra_pkg::IR_W'($urandom_range(32'(thr), IR_MAX));
        if (r < 80 && thr != '0) return bra_pkg::IR_W'($urandom_range(0, 32'(thr) - 1));
        return bra_pkg::IR_W'($urandom_range(0, IR_MAX));
    endfunction

    function automatic logic [bra_pkg::TIME_W-1:0] pick_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return bra_pkg::TIME_W'($urandom_range(1, 400));
        if (r < 85) return '0;
        if (r < 95) return bra_pkg::TIME_W'($urandom_range(400, 4000));
        return bra_pkg::TIME_W'($urandom);
    endfunction

    task automatic send_sample(input logic [bra_pkg::IR_W-1:0] ir, input logic beat,
                               input logic [bra_pkg::TIME_W-1:0] now);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_ir_sample <= ir;
        i_beat_seen <= beat;
        i_now_ms    <= now;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [bra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bra_pkg::CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_bounds(input logic [bra_pkg::IR_W-1:0] thr,
                              input logic [bra_pkg::FLOOR_W-1:0] lo,
                              input logic [bra_pkg::CEIL_W-1:0] hi);
        wait_all_results();
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, bra_pkg::CFG_DAT_W'($urandom));
        write_reg(bra_pkg::CFG_PRESENCE, bra_pkg::CFG_DAT_W'(thr));
        write_reg(bra_pkg::CFG_FLOOR, bra_pkg::CFG_DAT_W'(lo));
        write_reg(bra_pkg::CFG_CEILING, bra_pkg::CFG_DAT_W'(hi));
        cur_threshold = thr;
    endtask

    task automatic beat_after(input logic [bra_pkg::IR_W-1:0] ir,
                              input logic [bra_pkg::TIME_W-1:0] delta);
        stamp = stamp + delta;
        send_sample(ir, 1'b1, stamp);
    endtask

    // output side back-pressure
    initial begin : out_side
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30) stall = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;
        int per_phase;
        logic beat;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, starting under reset bounds
        send_sample('0, 1'b0, '0);
        stamp = 32'd1000;
        send_sample(bra_pkg::IR_W'(IR_MAX), 1'b1, stamp);
        send_sample(bra_pkg::IR_W'(20000), 1'b1, stamp);
        beat_after(bra_pkg::IR_W'(20000), 32'd500);
        beat_after(bra_pkg::IR_W'(20000), 32'd235);
        beat_after(bra_pkg::IR_W'(20000), 32'd236);
        beat_after(bra_pkg::IR_W'(20000), 32'd3000);
        beat_after(bra_pkg::IR_W'(20000), 32'd2999);
        beat_after(bra_pkg::IR_W'(4999), 32'd500);
        send_sample(bra_pkg::IR_W'(5000), 1'b0, 32'hFFFF_FFFF);
        stamp = 32'hFFFF_FF00;
        send_sample(bra_pkg::IR_W'(5000), 1'b1, stamp);
        stamp = 32'h0000_00F0;
        send_sample(bra_pkg::IR_W'(5000), 1'b1, stamp);

        wait_all_results();
        write_reg(CFG_UNUSED, '1);
        set_bounds('0, 8'd0, 10'd1023);
        beat_after('0, 32'd1);
        beat_after('0, 32'd59);
        beat_after('0, 32'd60001);
        beat_after(bra_pkg::IR_W'(IR_MAX), 32'd58);

        set_bounds('1, 8'd255, 10'd1);
        beat_after(bra_pkg::IR_W'(IR_MAX), 32'd100);
        beat_after(bra_pkg::IR_W'(IR_MAX - 1), 32'd300);
        set_bounds('1, 8'd1, 10'd0);
        beat_after(bra_pkg::IR_W'(IR_MAX), 32'd1000);
        set_bounds('0, 8'd255, 10'd1023);
        beat_after(bra_pkg::IR_W'(IR_MAX), 32'd235);
        beat_after(bra_pkg::IR_W'(IR_MAX), 32'd1);

        // random part, one bound setting per phase
        per_phase = RANDOM_SAMPLES / PHASES;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_bounds(bra_pkg::PRESENCE_RST, bra_pkg::FLOOR_RST, bra_pkg::CEILING_RST);
                1: set_bounds('0, 8'd1, 10'd1023);
                2: set_bounds('1, 8'd255, 10'd1023);
                3: set_bounds(bra_pkg::IR_W'($urandom_range(0, 20000)), 8'd0,
                              bra_pkg::CEIL_W'($urandom_range(300, 1023)));
                4: set_bounds(bra_pkg::IR_W'($urandom_range(0, IR_MAX)), 8'd200, 10'd150);
                default: set_bounds(bra_pkg::IR_W'($urandom_range(0, IR_MAX)),
                                    bra_pkg::FLOOR_W'($urandom_range(1, 60)),
                                    bra_pkg::CEIL_W'($urandom_range(100, 1023)));
            endcase
            for (n = 0; n < per_phase; n++) begin
                if ($urandom_range(0, 49) == 0) calm = !calm;
                if ($urandom_range(0, 99) == 0) wait_all_results();
                stamp = stamp + pick_step();
                beat = ($urandom_range(0, 99) < 40);
                send_sample(pick_ir(cur_threshold), beat, stamp);
            end
        end

        calm = 1'b0;
        wait_all_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
